// ===== rtl/arci_pkg.sv =====
// Shared types and constants of the ATA read command issuer.
package arci_pkg;

	localparam int CapW = 48;

	// register indexes on the configuration port
	localparam logic [2:0] REG_MASTER_MODE = 3'd0;
	localparam logic [2:0] REG_SLAVE_MODE  = 3'd1;
	localparam logic [2:0] REG_MASTER_CAP  = 3'd2;
	localparam logic [2:0] REG_SLAVE_CAP   = 3'd3;
	localparam logic [2:0] REG_MASTER_GEOM = 3'd4;
	localparam logic [2:0] REG_SLAVE_GEOM  = 3'd5;

	localparam logic [1:0] ST_WRITE   = 2'd0;
	localparam logic [1:0] ST_REJECT  = 2'd1;
	localparam logic [1:0] ST_NOTHING = 2'd2;

	localparam logic [2:0] PO_NONE  = 3'd0;
	localparam logic [2:0] PO_COUNT = 3'd2;
	localparam logic [2:0] PO_ADDR0 = 3'd3;
	localparam logic [2:0] PO_ADDR1 = 3'd4;
	localparam logic [2:0] PO_ADDR2 = 3'd5;
	localparam logic [2:0] PO_DH    = 3'd6;
	localparam logic [2:0] PO_CMD   = 3'd7;

	localparam logic [7:0] DH_BASE      = 8'hA0;
	localparam logic [7:0] DH_LBA       = 8'h40;
	localparam logic [7:0] DH_SLAVE     = 8'h10;
	localparam logic [7:0] DH_HI_MASK   = 8'hF0;
	localparam logic [7:0] CMD_READ     = 8'h20;
	localparam logic [7:0] CMD_READ_EXT = 8'h24;

	localparam logic [1:0] SEL_NONE = 2'd2;

	typedef enum logic [2:0] {
		JOB_REJECT,
		JOB_NOTHING,
		JOB_LBA48,
		JOB_LBA28,
		JOB_CHS
	} job_kind_t;

	typedef struct packed {
		job_kind_t         kind;
		logic              drive;
		logic [CapW-1:0]   lba;
		logic [15:0]       cnt;
		logic [7:0]        spt;
		logic [7:0]        heads;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_LOAD,
		BK_DIV_CYL,
		BK_DIV_HEAD,
		BK_PREP,
		BK_EMIT
	} back_state_t;

endpackage

// ===== rtl/arci_front.sv =====
// Front end: configuration registers, request checks and job classification.
module arci_front #(
	parameter int LBA_WIDTH = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [5:0]           paddr,
	input  logic [63:0]          pwdata,
	output logic [63:0]          prdata,
	input  logic                 drive,
	input  logic [47:0]          lba,
	input  logic [15:0]          sector_count,
	output arci_pkg::job_t       job
);
	import arci_pkg::*;

	localparam logic [CapW-1:0] LBA_MASK = CapW'((49'd1 << LBA_WIDTH) - 49'd1);

	logic [2:0]      master_mode_q, slave_mode_q;
	logic [CapW-1:0] master_cap_q, slave_cap_q;
	logic [15:0]     master_geom_q, slave_geom_q;
	logic [2:0]      reg_idx;
	logic            wr_en;

	assign reg_idx = paddr[5:3];
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_mode_q <= '0;
			slave_mode_q  <= '0;
			master_cap_q  <= '0;
			slave_cap_q   <= '0;
			master_geom_q <= '0;
			slave_geom_q  <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MASTER_MODE: master_mode_q <= pwdata[2:0];
				REG_SLAVE_MODE:  slave_mode_q  <= pwdata[2:0];
				REG_MASTER_CAP:  master_cap_q  <= pwdata[CapW-1:0];
				REG_SLAVE_CAP:   slave_cap_q   <= pwdata[CapW-1:0];
				REG_MASTER_GEOM: master_geom_q <= pwdata[15:0];
				REG_SLAVE_GEOM:  slave_geom_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MASTER_MODE: prdata = {61'd0, master_mode_q};
			REG_SLAVE_MODE:  prdata = {61'd0, slave_mode_q};
			REG_MASTER_CAP:  prdata = {16'd0, master_cap_q};
			REG_SLAVE_CAP:   prdata = {16'd0, slave_cap_q};
			REG_MASTER_GEOM: prdata = {48'd0, master_geom_q};
			REG_SLAVE_GEOM:  prdata = {48'd0, slave_geom_q};
			default:         prdata = '0;
		endcase
	end

	logic [2:0]      mode;
	logic [CapW-1:0] cap, lba_m;
	logic [15:0]     geom;
	logic            use_lba, use_lba48;

	always_comb begin
		mode      = drive ? slave_mode_q : master_mode_q;
		cap       = drive ? slave_cap_q : master_cap_q;
		geom      = drive ? slave_geom_q : master_geom_q;
		lba_m     = lba & LBA_MASK;
		use_lba   = mode[1];
		use_lba48 = mode[1] & mode[2];

		job.drive = drive;
		job.lba   = lba_m;
		job.cnt   = sector_count;
		job.spt   = geom[7:0];
		job.heads = geom[15:8];

		// check order: presence, capacity, zero count, count width, geometry
		if (!mode[0] || lba_m >= cap)
			job.kind = JOB_REJECT;
		else if (sector_count == 16'd0)
			job.kind = JOB_NOTHING;
		else if (!use_lba48 && sector_count[15:8] != 8'd0)
			job.kind = JOB_REJECT;
		else if (!use_lba && (geom[7:0] == 8'd0 || geom[15:8] == 8'd0))
			job.kind = JOB_REJECT;
		else if (use_lba48)
			job.kind = JOB_LBA48;
		else if (use_lba)
			job.kind = JOB_LBA28;
		else
			job.kind = JOB_CHS;
	end

endmodule

// ===== rtl/arci_queue.sv =====
// Two-entry job queue between front and back.
module arci_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  arci_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output arci_pkg::job_t head_job
);
	import arci_pkg::*;

	job_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign head_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/arci_back.sv =====
// Back end: CHS divider, drive-select tracking and task-file beat sequencer.
module arci_back #(
	parameter int LBA_WIDTH = 48
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  arci_pkg::job_t q_job,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [2:0]     port_offset,
	output logic [7:0]     write_byte,
	output logic [1:0]     status,
	output logic           last
);
	import arci_pkg::*;

	localparam int StepW = $clog2(LBA_WIDTH + 1);

	back_state_t state_q, state_d;
	job_t        job_q;

	logic [1:0]  sel_q;
	logic [7:0]  dh_q;

	logic [15:0]          spc_q;
	logic [15:0]          rem_q;
	logic [LBA_WIDTH-1:0] quo_q;
	logic [StepW-1:0]     step_q;
	logic [15:0]          cyl_q;
	logic [3:0]           head_q;
	logic [7:0]           sec_q;

	logic                 sel_pend_q;
	logic [7:0]           dh_sel_q, dh_main_q, b3_q, b4_q, b5_q;
	logic [3:0]           k_q;

	logic                 out_valid_q;
	logic [2:0]           po_q;
	logic [7:0]           wb_q;
	logic [1:0]           st_q;
	logic                 last_q;

	// restoring divider step, one quotient bit a cycle
	logic [15:0] dvs;
	logic [16:0] trial;
	logic        ge;
	logic [15:0] rem_nx;

	always_comb begin
		dvs    = (state_q == BK_DIV_CYL) ? spc_q : {8'd0, job_q.spt};
		trial  = {rem_q, quo_q[LBA_WIDTH-1]};
		ge     = trial >= {1'b0, dvs};
		rem_nx = ge ? 16'(trial - {1'b0, dvs}) : trial[15:0];
	end

	// current beat
	logic       beat_ok, load_out, adv;
	logic [2:0] b_po;
	logic [7:0] b_wb;
	logic [1:0] b_st;
	logic       b_last;

	always_comb begin
		b_po   = PO_NONE;
		b_wb   = 8'd0;
		b_st   = ST_WRITE;
		b_last = 1'b0;
		if (job_q.kind == JOB_REJECT || job_q.kind == JOB_NOTHING) begin
			b_st   = (job_q.kind == JOB_REJECT) ? ST_REJECT : ST_NOTHING;
			b_last = 1'b1;
		end else if (sel_pend_q) begin
			b_po = PO_DH;
			b_wb = dh_sel_q;
		end else if (job_q.kind == JOB_LBA48) begin
			b_last = (k_q == 4'd9);
			case (k_q)
				4'd0: begin b_po = PO_DH;    b_wb = dh_main_q;            end
				4'd1: begin b_po = PO_COUNT; b_wb = job_q.cnt[15:8];      end
				4'd2: begin b_po = PO_ADDR0; b_wb = job_q.lba[31:24];     end
				4'd3: begin b_po = PO_ADDR1; b_wb = job_q.lba[39:32];     end
				4'd4: begin b_po = PO_ADDR2; b_wb = job_q.lba[47:40];     end
				4'd5: begin b_po = PO_COUNT; b_wb = job_q.cnt[7:0];       end
				4'd6: begin b_po = PO_ADDR0; b_wb = job_q.lba[7:0];       end
				4'd7: begin b_po = PO_ADDR1; b_wb = job_q.lba[15:8];      end
				4'd8: begin b_po = PO_ADDR2; b_wb = job_q.lba[23:16];     end
				default: begin b_po = PO_CMD; b_wb = CMD_READ_EXT;        end
			endcase
		end else begin
			b_last = (k_q == 4'd5);
			case (k_q)
				4'd0: begin b_po = PO_DH;    b_wb = dh_main_q;      end
				4'd1: begin b_po = PO_COUNT; b_wb = job_q.cnt[7:0]; end
				4'd2: begin b_po = PO_ADDR0; b_wb = b3_q;           end
				4'd3: begin b_po = PO_ADDR1; b_wb = b4_q;           end
				4'd4: begin b_po = PO_ADDR2; b_wb = b5_q;           end
				default: begin b_po = PO_CMD; b_wb = CMD_READ;      end
			endcase
		end
	end

	assign beat_ok  = !out_valid_q || out_ready;
	assign load_out = (state_q == BK_EMIT) && beat_ok;
	assign adv      = load_out;
	assign q_pop    = (state_q == BK_IDLE) && !q_empty;

	// selection state as it would stand after this job
	logic       need_sel;
	logic [7:0] dh_sel, dh_base, dh_main;
	logic [3:0] nib;

	always_comb begin
		need_sel = (sel_q != {1'b0, job_q.drive});
		dh_sel   = DH_BASE
			| ((job_q.kind == JOB_CHS) ? 8'd0 : DH_LBA)
			| (job_q.drive ? DH_SLAVE : 8'd0);
		dh_base  = need_sel ? dh_sel : dh_q;
		case (job_q.kind)
			JOB_LBA28: nib = job_q.lba[27:24];
			JOB_CHS:   nib = head_q;
			default:   nib = 4'd0;
		endcase
		dh_main = (dh_base & DH_HI_MASK) | {4'd0, nib};
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:     if (!q_empty) state_d = BK_LOAD;
			BK_LOAD:     state_d = (job_q.kind == JOB_CHS) ? BK_DIV_CYL : BK_PREP;
			BK_DIV_CYL:  if (step_q == StepW'(1)) state_d = BK_DIV_HEAD;
			BK_DIV_HEAD: if (step_q == StepW'(1)) state_d = BK_PREP;
			BK_PREP:     state_d = BK_EMIT;
			BK_EMIT:     if (adv && !sel_pend_q && b_last) state_d = BK_IDLE;
			default:     state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q       <= SEL_NONE;
			dh_q        <= DH_BASE;
			sel_pend_q  <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == BK_PREP && job_q.kind != JOB_REJECT
					&& job_q.kind != JOB_NOTHING) begin
				sel_q      <= {1'b0, job_q.drive};
				dh_q       <= dh_main;
				sel_pend_q <= need_sel;
			end
			if (state_q == BK_PREP)
				k_q <= '0;
			if (adv) begin
				if (sel_pend_q && job_q.kind != JOB_REJECT && job_q.kind != JOB_NOTHING)
					sel_pend_q <= 1'b0;
				else
					k_q <= k_q + 4'd1;
			end
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			job_q <= q_job;
		if (state_q == BK_LOAD) begin
			spc_q  <= 16'(job_q.spt * job_q.heads);
			quo_q  <= job_q.lba[LBA_WIDTH-1:0];
			rem_q  <= '0;
			step_q <= StepW'(LBA_WIDTH);
		end
		if (state_q == BK_DIV_CYL) begin
			if (step_q == StepW'(1)) begin
				// keep cylinder, divide the remainder by sectors per track
				cyl_q  <= {quo_q[14:0], ge};
				quo_q  <= {rem_nx, {(LBA_WIDTH-16){1'b0}}};
				rem_q  <= '0;
				step_q <= StepW'(16);
			end else begin
				quo_q  <= {quo_q[LBA_WIDTH-2:0], ge};
				rem_q  <= rem_nx;
				step_q <= step_q - StepW'(1);
			end
		end
		if (state_q == BK_DIV_HEAD) begin
			quo_q  <= {quo_q[LBA_WIDTH-2:0], ge};
			rem_q  <= rem_nx;
			step_q <= step_q - StepW'(1);
			if (step_q == StepW'(1)) begin
				head_q <= {quo_q[2:0], ge};
				sec_q  <= rem_nx[7:0] + 8'd1;
			end
		end
		if (state_q == BK_PREP) begin
			dh_sel_q  <= dh_sel;
			dh_main_q <= dh_main;
			if (job_q.kind == JOB_CHS) begin
				b3_q <= sec_q;
				b4_q <= cyl_q[7:0];
				b5_q <= cyl_q[15:8];
			end else begin
				b3_q <= job_q.lba[7:0];
				b4_q <= job_q.lba[15:8];
				b5_q <= job_q.lba[23:16];
			end
		end
		if (load_out) begin
			po_q   <= b_po;
			wb_q   <= b_wb;
			st_q   <= b_st;
			last_q <= b_last && !(sel_pend_q && b_st == ST_WRITE);
		end
	end

	assign out_valid   = out_valid_q;
	assign port_offset = po_q;
	assign write_byte  = wb_q;
	assign status      = st_q;
	assign last        = last_q;

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && b_st != ST_WRITE |-> b_last)
		else $error("non-write beat without last");
	a_sel_code: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q != 2'd3)
		else $error("selected drive code out of range");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && b_last && !sel_pend_q |=> state_q == BK_IDLE)
		else $error("sequencer did not return to idle after last beat");

endmodule

// ===== rtl/ata_read_command_issuer.sv =====
// Top level of the ATA read command issuer.
// Usage:
//   A read request (drive, lba, sector_count) enters on the in_valid/in_ready
//   channel. Each request yields one to eleven beats on the out_valid/out_ready
//   channel: task-file writes (status 0) as port_offset/write_byte pairs, or a
//   single reject (status 1) or nothing-to-do (status 2) beat. The final beat
//   of a request carries last.
//   Drive modes, capacities and geometry are written over the APB-style port
//   at byte addresses 8*i; pready is tied high.
// Throughput:
//   LBA requests, once emitting, give one beat per cycle while out_ready is
//   high. CHS requests first run a shared restoring divider, one quotient bit
//   per cycle: first for the cylinder, then for head and sector.
//   A two-entry queue lets the front take new requests while the back works.
// Reset:
//   All registers read zero, no drive is selected, so the first request that
//   is carried out always writes a drive-select beat.
// Stall:
//   When out_ready is low the beat holds in the output register and the
//   sequencer waits; the queue fills and in_ready drops once it is full.
module ata_read_command_issuer #(
	parameter int LBA_WIDTH = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        drive,
	input  logic [47:0] lba,
	input  logic [15:0] sector_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  port_offset,
	output logic [7:0]  write_byte,
	output logic [1:0]  status,
	output logic        last
);
	import arci_pkg::*;

	job_t front_job, head_job;
	logic q_full, q_empty, q_pop, q_push;

	assign pready   = 1'b1;
	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	// classify the request in the beat it is accepted
	arci_front #(.LBA_WIDTH(LBA_WIDTH)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.drive        (drive),
		.lba          (lba),
		.sector_count (sector_count),
		.job          (front_job)
	);

	// decouple classification from execution
	arci_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (front_job),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head_job (head_job)
	);

	// divide, track the selected drive, and emit beats
	arci_back #(.LBA_WIDTH(LBA_WIDTH)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_job       (head_job),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.port_offset (port_offset),
		.write_byte  (write_byte),
		.status      (status),
		.last        (last)
	);

endmodule

// ===== dv/tb_ata_read_command_issuer.sv =====
// Testbench for the ATA read command issuer: directed table plus random requests.
`timescale 1ns / 100ps

module tb_ata_read_command_issuer;
	import arci_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 120;
	localparam int RANDOM_REQS = 360;

	// one task-file beat as seen on the result channel
	typedef struct packed {
		logic [2:0] port;
		logic [7:0] data;
		logic [1:0] stat;
		logic       fin;
	} tf_beat_t;

	// one row of the directed table; n_typed = 0 means use the predictor
	typedef struct {
		logic        drv;
		logic [47:0] addr;
		logic [15:0] cnt;
		int          n_typed;
		tf_beat_t    typed;
	} req_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	logic        drive;
	logic [47:0] lba;
	logic [15:0] sector_count;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  port_offset;
	logic [7:0]  write_byte;
	logic [1:0]  status;
	logic        last;

	// predictor copy of the configuration and the selection state
	logic [2:0]  mode_q [2];
	logic [47:0] cap_q [2];
	logic [15:0] geom_q [2];
	logic [1:0]  sel_drive_q;
	logic [7:0]  dh_q;

	tf_beat_t pending_beats [$];
	int       fail_count;
	int       idle_cycles;
	bit       timed_out;

	ata_read_command_issuer u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.drive(drive), .lba(lba), .sector_count(sector_count),
		.out_valid(out_valid), .out_ready(out_ready),
		.port_offset(port_offset), .write_byte(write_byte),
		.status(status), .last(last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic tf_beat_t mk_beat(logic [2:0] p, logic [7:0] d, logic [1:0] s);
		tf_beat_t b;
		b.port = p;
		b.data = d;
		b.stat = s;
		b.fin = 1'b0;
		return b;
	endfunction

	// Work out the task-file beats of one read request and advance the state.
	task automatic issue_read_beats(input logic drv, input logic [47:0] addr,
			input logic [15:0] cnt);
		tf_beat_t    seq [$];
		logic [2:0]  md;
		logic        present, by_lba, by_lba48;
		logic [7:0]  spt, heads, dh;
		logic [63:0] spc, hd, cyl, sec;
		md = mode_q[drv];
		present = md[0];
		by_lba = md[1];
		by_lba48 = md[1] & md[2];
		spt = geom_q[drv][7:0];
		heads = geom_q[drv][15:8];
		if (!present || addr >= cap_q[drv])
			seq.push_back(mk_beat(PO_NONE, 8'h00, ST_REJECT));
		else if (cnt == 16'd0)
			seq.push_back(mk_beat(PO_NONE, 8'h00, ST_NOTHING));
		else if (!by_lba48 && cnt > 16'd255)
			seq.push_back(mk_beat(PO_NONE, 8'h00, ST_REJECT));
		else if (!by_lba && (spt == 8'd0 || heads == 8'd0))
			seq.push_back(mk_beat(PO_NONE, 8'h00, ST_REJECT));
		else begin
			if (sel_drive_q != {1'b0, drv}) begin
				dh = DH_BASE | (by_lba ? DH_LBA : 8'h00) | (drv ? DH_SLAVE : 8'h00);
				dh_q = dh;
				seq.push_back(mk_beat(PO_DH, dh, ST_WRITE));
				sel_drive_q = {1'b0, drv};
			end
			dh_q = dh_q & DH_HI_MASK;
			if (by_lba48) begin
				seq.push_back(mk_beat(PO_DH, dh_q, ST_WRITE));
				seq.push_back(mk_beat(PO_COUNT, cnt[15:8], ST_WRITE));
				seq.push_back(mk_beat(PO_ADDR0, addr[31:24], ST_WRITE));
				seq.push_back(mk_beat(PO_ADDR1, addr[39:32], ST_WRITE));
				seq.push_back(mk_beat(PO_ADDR2, addr[47:40], ST_WRITE));
				seq.push_back(mk_beat(PO_COUNT, cnt[7:0], ST_WRITE));
				seq.push_back(mk_beat(PO_ADDR0, addr[7:0], ST_WRITE));
				seq.push_back(mk_beat(PO_ADDR1, addr[15:8], ST_WRITE));
				seq.push_back(mk_beat(PO_ADDR2, addr[23:16], ST_WRITE));
				seq.push_back(mk_beat(PO_CMD, CMD_READ_EXT, ST_WRITE));
			end else if (by_lba) begin
				dh_q = dh_q | {4'h0, addr[27:24]};
				seq.push_back(mk_beat(PO_DH, dh_q, ST_WRITE));
				seq.push_back(mk_beat(PO_COUNT, cnt[7:0], ST_WRITE));
				seq.push_back(mk_beat(PO_ADDR0, addr[7:0], ST_WRITE));
				seq.push_back(mk_beat(PO_ADDR1, addr[15:8], ST_WRITE));
				seq.push_back(mk_beat(PO_ADDR2, addr[23:16], ST_WRITE));
				seq.push_back(mk_beat(PO_CMD, CMD_READ, ST_WRITE));
			end else begin
				spc = 64'(spt) * 64'(heads);
				hd = ((64'(addr) % spc) / 64'(spt)) & 64'hF;
				cyl = (64'(addr) / spc) & 64'hFFFF;
				sec = ((64'(addr) % 64'(spt)) + 64'd1) & 64'hFF;
				dh_q = dh_q | hd[7:0];
				seq.push_back(mk_beat(PO_DH, dh_q, ST_WRITE));
				seq.push_back(mk_beat(PO_COUNT, cnt[7:0], ST_WRITE));
				seq.push_back(mk_beat(PO_ADDR0, sec[7:0], ST_WRITE));
				seq.push_back(mk_beat(PO_ADDR1, cyl[7:0], ST_WRITE));
				seq.push_back(mk_beat(PO_ADDR2, cyl[15:8], ST_WRITE));
				seq.push_back(mk_beat(PO_CMD, CMD_READ, ST_WRITE));
			end
		end
		seq[seq.size() - 1].fin = 1'b1;
		foreach (seq[i])
			pending_beats.push_back(seq[i]);
	endtask

	// Write one register over APB: setup cycle, then access cycle.
	task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MASTER_MODE: mode_q[0] = val[2:0];
			REG_SLAVE_MODE:  mode_q[1] = val[2:0];
			REG_MASTER_CAP:  cap_q[0] = val[47:0];
			REG_SLAVE_CAP:   cap_q[1] = val[47:0];
			REG_MASTER_GEOM: geom_q[0] = val[15:0];
			REG_SLAVE_GEOM:  geom_q[1] = val[15:0];
			default: ;
		endcase
	endtask

	task automatic set_drives(input logic [2:0] m0, input logic [2:0] m1,
			input logic [47:0] c0, input logic [47:0] c1,
			input logic [15:0] g0, input logic [15:0] g1);
		reg_write(REG_MASTER_MODE, 64'(m0));
		reg_write(REG_SLAVE_MODE, 64'(m1));
		reg_write(REG_MASTER_CAP, 64'(c0));
		reg_write(REG_SLAVE_CAP, 64'(c1));
		reg_write(REG_MASTER_GEOM, 64'(g0));
		reg_write(REG_SLAVE_GEOM, 64'(g1));
	endtask

	// Drop valid, drain every expected beat, then hold off for the CHS divider to settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_beats.size() != 0 && !timed_out)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Offer one request; the sender bursts and leaves random gaps.
	// A typed row supplies its own expected beat instead of the predictor's.
	int burst_left;
	task automatic send_req(input logic drv, input logic [47:0] addr, input logic [15:0] cnt,
			input int n_typed = 0, input tf_beat_t typed = '0);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		drive <= drv;
		lba <= addr;
		sector_count <= cnt;
		@(posedge clk);
		while (!in_ready && !timed_out)
			@(posedge clk);
		if (n_typed != 0)
			pending_beats.push_back(typed);
		else
			issue_read_beats(drv, addr, cnt);
	endtask

	// Receiver stall pattern: switch between free-running and random stall phases.
	int stall_phase;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_phase <= 0;
		end else begin
			stall_phase <= (stall_phase + 1) % 200;
			if (stall_phase < 60)
				out_ready <= 1'b1;
			else if (stall_phase < 130)
				out_ready <= ($urandom_range(0, 3) != 0);
			else
				out_ready <= ($urandom_range(0, 1) == 0);
		end
	end

	// Compare each accepted beat against the oldest expectation.
	tf_beat_t want;
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_beats.size() == 0) begin
				$error("unexpected beat port=%0d byte=%02h status=%0d last=%0b",
					port_offset, write_byte, status, last);
				fail_count++;
			end else begin
				want = pending_beats.pop_front();
				if (port_offset !== want.port) begin
					$error("port_offset expected %0d actual %0d", want.port, port_offset);
					fail_count++;
				end
				if (write_byte !== want.data) begin
					$error("write_byte expected %02h actual %02h", want.data, write_byte);
					fail_count++;
				end
				if (status !== want.stat) begin
					$error("status expected %0d actual %0d", want.stat, status);
					fail_count++;
				end
				if (last !== want.fin) begin
					$error("last expected %0b actual %0b", want.fin, last);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: count cycles with no beat on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("tb_ata_read_command_issuer NOT OK");
			$finish;
		end
	end

	function automatic logic [47:0] rand48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// Mostly in-range addresses; sometimes at or past capacity or fully random.
	function automatic logic [47:0] pick_addr(input logic [47:0] c);
		int k;
		k = $urandom_range(0, 9);
		if (k == 0)
			return rand48();
		if (k == 1 && c != 0)
			return c - 48'd1;
		if (k == 2)
			return c;
		if (c == 0)
			return rand48();
		return rand48() % c;
	endfunction

	function automatic logic [15:0] pick_cnt();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0)
			return 16'd0;
		if (k == 1)
			return 16'($urandom);
		if (k == 2)
			return 16'hFFFF;
		return 16'($urandom_range(1, 255));
	endfunction

	req_row_t dir_rows [$];
	req_row_t row;
	int       ph;
	logic     d;

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		drive = 1'b0;
		lba = '0;
		sector_count = '0;
		fail_count = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		burst_left = 0;
		mode_q[0] = '0; mode_q[1] = '0;
		cap_q[0] = '0; cap_q[1] = '0;
		geom_q[0] = '0; geom_q[1] = '0;
		sel_drive_q = SEL_NONE;
		dh_q = DH_BASE;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Right after reset no drive is present: every request is rejected.
		dir_rows.push_back('{1'b0, 48'd0, 16'd1, 1, '{PO_NONE, 8'h00, ST_REJECT, 1'b1}});
		dir_rows.push_back('{1'b1, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1,
			'{PO_NONE, 8'h00, ST_REJECT, 1'b1}});
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			send_req(row.drv, row.addr, row.cnt, row.n_typed, row.typed);
		end
		wait_idle();

		// Master LBA48 at full capacity, slave 28-bit LBA.
		set_drives(3'b111, 3'b011, 48'hFFFF_FFFF_FFFF, 48'h0FFF_FFFF, 16'h0000, 16'h0000);
		dir_rows.delete();
		dir_rows.push_back('{1'b0, 48'd0, 16'd0, 1, '{PO_NONE, 8'h00, ST_NOTHING, 1'b1}});
		dir_rows.push_back('{1'b0, 48'hFFFF_FFFF_FFFF, 16'd1, 1,
			'{PO_NONE, 8'h00, ST_REJECT, 1'b1}});
		dir_rows.push_back('{1'b0, 48'hFFFF_FFFF_FFFE, 16'hFFFF, 0, '0});
		dir_rows.push_back('{1'b0, 48'h1234_5678_9ABC, 16'h0100, 0, '0});
		dir_rows.push_back('{1'b1, 48'h0FFF_FFFE, 16'd255, 0, '0});
		dir_rows.push_back('{1'b1, 48'h0ABC_DEF0, 16'd256, 1,
			'{PO_NONE, 8'h00, ST_REJECT, 1'b1}});
		dir_rows.push_back('{1'b1, 48'd0, 16'd1, 0, '0});
		dir_rows.push_back('{1'b0, 48'h5555_5555_5555, 16'h00AA, 0, '0});
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			send_req(row.drv, row.addr, row.cnt, row.n_typed, row.typed);
		end
		wait_idle();

		// Stale drive/head: change modes without reselecting; LBA48 bit without LBA is CHS.
		set_drives(3'b101, 3'b001, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'h0000);
		dir_rows.delete();
		dir_rows.push_back('{1'b0, 48'hFFFF_FFFF_FFFF, 16'd255, 0, '0});
		dir_rows.push_back('{1'b0, 48'd0, 16'd1, 0, '0});
		dir_rows.push_back('{1'b0, 48'd300, 16'd256, 1, '{PO_NONE, 8'h00, ST_REJECT, 1'b1}});
		dir_rows.push_back('{1'b1, 48'd5, 16'd1, 1, '{PO_NONE, 8'h00, ST_REJECT, 1'b1}});
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			send_req(row.drv, row.addr, row.cnt, row.n_typed, row.typed);
		end
		wait_idle();
		set_drives(3'b001, 3'b001, 48'hFFFF_FFFF_FFFF, 48'd100000, 16'h0100, 16'h0001);
		dir_rows.delete();
		dir_rows.push_back('{1'b0, 48'hABCD_1234, 16'd7, 0, '0});
		dir_rows.push_back('{1'b1, 48'd99999, 16'd1, 0, '0});
		dir_rows.push_back('{1'b1, 48'd100000, 16'd1, 1, '{PO_NONE, 8'h00, ST_REJECT, 1'b1}});
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			send_req(row.drv, row.addr, row.cnt, row.n_typed, row.typed);
		end
		wait_idle();

		// Random phases: new drive settings each phase, then a run of requests.
		for (ph = 0; ph < 12 && !timed_out; ph++) begin
			set_drives(3'($urandom_range(0, 7)) | 3'b001, 3'($urandom_range(0, 7)),
				($urandom_range(0, 3) == 0) ? 48'hFFFF_FFFF_FFFF : rand48() >> $urandom_range(0, 40),
				($urandom_range(0, 3) == 0) ? 48'hFFFF_FFFF_FFFF : rand48() >> $urandom_range(0, 40),
				($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom),
				($urandom_range(0, 7) == 0) ? 16'hFF00 : 16'($urandom));
			for (int i = 0; i < RANDOM_REQS / 12 && !timed_out; i++) begin
				d = 1'($urandom_range(0, 1));
				send_req(d, pick_addr(cap_q[d]), pick_cnt());
			end
			wait_idle();
		end

		if (fail_count == 0)
			$display("tb_ata_read_command_issuer OK");
		else
			$display("tb_ata_read_command_issuer NOT OK");
		$finish;
	end

endmodule
